// ===== rtl/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
// Used by the slot pool, the top level and the port checker.
`default_nettype none

package stq_pkg;

  localparam int unsigned SlotCount = 64;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned CntW      = $clog2(SlotCount + 1);
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TagW      = 8;

  localparam logic [TimeW-1:0] NoDeadline = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CmdAlloc = 2'd0,
    CmdFree  = 2'd1,
    CmdBind  = 2'd2,
    CmdSet   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StNoSlot = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SqIdle,
    SqAlloc,
    SqSrchRd,
    SqSrchDl,
    SqSrchCmp,
    SqShRd,
    SqShWr,
    SqIns,
    SqHdRd,
    SqHdDl,
    SqHdUpd,
    SqResp
  } seq_e;

  typedef struct packed {
    logic             alloc;
    logic             mark;
    logic             clear;
    logic [SlotW-1:0] slot;
  } pool_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [SlotW-1:0] given;
  } pool_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/stq_slot_pool.sv =====
// Slot pool: one in-use flag per timer slot and a one-slot-per-cycle
// scan for the lowest free slot. Depends on stq_pkg.
`default_nettype none

module stq_slot_pool
  import stq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pool_req_t req_i,
  output pool_rsp_t      rsp_o
);

  logic [SlotCount-1:0] used_q;
  logic                 scan_q;
  logic [SlotW-1:0]     idx_q;
  logic                 hit;
  logic                 last;

  assign hit  = scan_q && !used_q[idx_q];
  assign last = (idx_q == SlotW'(SlotCount - 1));

  assign rsp_o.done  = scan_q && (hit || last);
  assign rsp_o.found = hit;
  assign rsp_o.given = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      scan_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (req_i.clear) begin
        used_q[req_i.slot] <= 1'b0;
      end
      if (req_i.mark) begin
        used_q[req_i.slot] <= 1'b1;
      end
      if (req_i.alloc) begin
        scan_q <= 1'b1;
        idx_q  <= '0;
      end else if (scan_q) begin
        if (hit) begin
          used_q[idx_q] <= 1'b1;
          scan_q        <= 1'b0;
        end else if (last) begin
          scan_q <= 1'b0;
        end else begin
          idx_q <= idx_q + SlotW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_timer_queue_unit.sv =====
// Top level of the sorted timer queue: command sequencer, ordered list and
// deadline stores. Depends on stq_pkg and stq_slot_pool.
`default_nettype none

// A command is taken when start is high and busy is low; its one result
// appears with done_o high for a single cycle and must be taken then, the
// receiver cannot stall it. Free and bind go straight to the result. Alloc
// scans the slot pool one slot per cycle from slot 0 up to the lowest free
// slot, or to the last slot when no slot is free. Set walks the ordered
// list through its one read port and the deadline store: each entry read in
// the search (the entries passed and the one it stops at) goes through a
// read, a deadline read and a compare step, each entry moved to open the
// gap through a read and a write step, then the insert, a head read, a head
// deadline read, the head update and the result step follow. A set on a full
// list returns at once with the list-full status.
module sorted_timer_queue_unit
  import stq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command_i,
  input  wire logic [SlotW-1:0] slot_id_i,
  input  wire logic [TagW-1:0]  tag_byte_i,
  input  wire logic [TimeW-1:0] timeout_ticks_i,
  input  wire logic [TimeW-1:0] now_time_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [SlotW-1:0]      given_slot_o,
  output logic [TimeW-1:0]      next_deadline_o,
  output logic [CntW-1:0]       active_count_o
);

  seq_e              state_q, state_d;
  logic [CntW-1:0]   len_q, len_d;
  logic [TimeW-1:0]  earliest_q, earliest_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [CntW-1:0]   km1;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [TimeW-1:0]  dl_new_q, dl_new_d;
  status_e           status_q, status_d;
  logic [SlotW-1:0]  given_q, given_d;

  logic [TimeW-1:0]  dl_sum;
  logic              in_range;
  logic              full;

  logic [SlotW-1:0]  ord_mem [SlotCount];
  logic [TimeW-1:0]  dl_mem  [SlotCount];
  logic [TagW-1:0]   tag_mem [SlotCount];
  logic [SlotW-1:0]  ord_rd_q;
  logic [TimeW-1:0]  dl_rd_q;
  logic              ord_we;
  logic [SlotW-1:0]  ord_waddr;
  logic [SlotW-1:0]  ord_wdata;
  logic [SlotW-1:0]  ord_raddr;
  logic              dl_we;
  logic              tag_we;

  pool_req_t         pool_req;
  pool_rsp_t         pool_rsp;

  stq_slot_pool u_pool (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (pool_req),
    .rsp_o (pool_rsp)
  );

  assign dl_sum   = now_time_i + timeout_ticks_i;
  assign in_range = {1'b0, slot_id_i} < CntW'(SlotCount);
  assign full     = (len_q == CntW'(SlotCount));
  assign km1      = k_q - CntW'(1);

  assign busy            = (state_q != SqIdle);
  assign status_o        = status_q;
  assign given_slot_o    = given_q;
  assign next_deadline_o = earliest_q;
  assign active_count_o  = len_q;

  // Ordered-list and deadline stores: one write and one registered read each cycle; tag store: write only
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[slot_id_i] <= dl_sum;
    end
    dl_rd_q <= dl_mem[ord_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[slot_id_i] <= tag_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SqIdle;
      len_q      <= '0;
      earliest_q <= NoDeadline;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      earliest_q <= earliest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    k_q      <= k_d;
    slot_q   <= slot_d;
    dl_new_q <= dl_new_d;
    status_q <= status_d;
    given_q  <= given_d;
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    earliest_d = earliest_q;
    pos_d      = pos_q;
    k_d        = k_q;
    slot_d     = slot_q;
    dl_new_d   = dl_new_q;
    status_d   = status_q;
    given_d    = given_q;
    ord_we     = 1'b0;
    ord_waddr  = k_q[SlotW-1:0];
    ord_wdata  = ord_rd_q;
    ord_raddr  = pos_q[SlotW-1:0];
    dl_we      = 1'b0;
    tag_we     = 1'b0;
    pool_req   = '0;
    pool_req.slot = slot_id_i;
    done_o     = 1'b0;

    unique case (state_q)
      SqIdle: begin
        if (start) begin
          slot_d   = slot_id_i;
          dl_new_d = dl_sum;
          status_d = StOk;
          given_d  = '0;
          unique case (cmd_e'(command_i))
            CmdAlloc: begin
              pool_req.alloc = 1'b1;
              state_d        = SqAlloc;
            end
            CmdFree: begin
              pool_req.clear = in_range;
              state_d        = SqResp;
            end
            CmdBind: begin
              tag_we  = in_range;
              state_d = SqResp;
            end
            CmdSet: begin
              if (!in_range) begin
                state_d = SqResp;
              end else if (full) begin
                status_d = StFull;
                state_d  = SqResp;
              end else begin
                // store deadline first, so a relisted slot compares with it
                dl_we         = 1'b1;
                pool_req.mark = 1'b1;
                pos_d         = '0;
                state_d       = SqSrchRd;
              end
            end
            default: state_d = SqResp;
          endcase
        end
      end
      SqAlloc: begin
        if (pool_rsp.done) begin
          if (pool_rsp.found) begin
            given_d = pool_rsp.given;
          end else begin
            status_d = StNoSlot;
          end
          state_d = SqResp;
        end
      end
      SqSrchRd: begin
        if (pos_q < len_q) begin
          state_d = SqSrchDl;
        end else begin
          k_d     = len_q;
          state_d = SqIns;
        end
      end
      SqSrchDl: begin
        state_d = SqSrchCmp;
      end
      SqSrchCmp: begin
        if (dl_rd_q < dl_new_q) begin
          pos_d   = pos_q + CntW'(1);
          state_d = SqSrchRd;
        end else begin
          k_d     = len_q;
          state_d = (len_q > pos_q) ? SqShRd : SqIns;
        end
      end
      SqShRd: begin
        ord_raddr = km1[SlotW-1:0];
        state_d   = SqShWr;
      end
      SqShWr: begin
        // move entry k-1 up to k
        ord_we    = 1'b1;
        ord_waddr = k_q[SlotW-1:0];
        ord_wdata = ord_rd_q;
        k_d       = km1;
        state_d   = (km1 > pos_q) ? SqShRd : SqIns;
      end
      SqIns: begin
        ord_we    = 1'b1;
        ord_waddr = pos_q[SlotW-1:0];
        ord_wdata = slot_q;
        len_d     = len_q + CntW'(1);
        state_d   = SqHdRd;
      end
      SqHdRd: begin
        ord_raddr = '0;
        state_d   = SqHdDl;
      end
      SqHdDl: begin
        state_d = SqHdUpd;
      end
      SqHdUpd: begin
        earliest_d = dl_rd_q;
        state_d    = SqResp;
      end
      SqResp: begin
        done_o  = 1'b1;
        state_d = SqIdle;
      end
      default: state_d = SqIdle;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/stq_checker.sv =====
// Port-level checker for sorted_timer_queue_unit, attached by bind.
// Depends on stq_pkg.
`default_nettype none

module stq_checker
  import stq_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       command_i,
  input wire logic [SlotW-1:0] slot_id_i,
  input wire logic [TagW-1:0]  tag_byte_i,
  input wire logic [TimeW-1:0] timeout_ticks_i,
  input wire logic [TimeW-1:0] now_time_i,
  input wire logic             done_o,
  input wire logic [1:0]       status_o,
  input wire logic [SlotW-1:0] given_slot_o,
  input wire logic [TimeW-1:0] next_deadline_o,
  input wire logic [CntW-1:0]  active_count_o
);

  // a result word only ends a command in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without a command in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");

  a_given_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> (given_slot_o == '0))
    else $error("granted slot on failed command");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_count_o != $past(active_count_o)) |->
      (active_count_o == $past(active_count_o) + CntW'(1)))
    else $error("list length moved by other than one");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_count_o <= CntW'(SlotCount)) else $error("list length above pool size");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

`default_nettype wire
